/* hdl/kl_pkg.sv */
// Shared types and codes for the keyed record list.
package kl_pkg;

    localparam int ID_W      = 31;
    localparam int DATA_W    = 32;
    localparam int OP_W      = 2;
    localparam int ST_W      = 2;
    localparam int CNT_OUT_W = 5;

    // operation codes (carried on the slave tuser)
    localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [OP_W-1:0] OP_POP    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // result status codes (carried on the master tuser)
    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

    // one stored record
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [DATA_W-1:0] data;
    } t_rec;

    // one result, apart from the record count
    typedef struct packed {
        logic [ST_W-1:0] status;
        t_rec            rec;
    } t_res;

endpackage

/* hdl/kl_store.sv */
// Record memory: one write port, one read port with registered read data.
module kl_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  kl_pkg::t_rec  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output kl_pkg::t_rec  o_rdata
);
    import kl_pkg::*;

    t_rec r_mem [DEPTH];
    t_rec r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/kl_ctrl.sv */
// Sequencer: push, pop, key search one entry a cycle, and gap closing.
module kl_ctrl #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int CW    = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // operation in
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_op,
    input  kl_pkg::t_rec     i_rec,
    // record memory
    output logic             o_we,
    output logic [AW-1:0]    o_waddr,
    output kl_pkg::t_rec     o_wdata,
    output logic [AW-1:0]    o_raddr,
    input  kl_pkg::t_rec     i_rdata,
    // result out
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output kl_pkg::t_res     o_res,
    output logic [CW-1:0]    o_count
);
    import kl_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_POP   = 3'd1;
    localparam logic [2:0] S_SRCH  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [2:0]      r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_idx, n_idx;
    logic [CW-1:0]   r_widx, n_widx;
    logic            r_pend, n_pend;
    logic [ID_W-1:0] r_key, n_key;
    t_res            r_res, n_res;

    logic            w_accept;
    logic            w_issue;
    logic            w_match;
    logic [CW-1:0]   w_count_m1;

    assign o_ready     = (r_state == S_IDLE);
    assign w_accept    = i_valid && o_ready;
    assign w_issue     = (r_idx < r_count);
    // key compare on the registered read data
    assign w_match     = r_pend && (i_rdata.id == r_key);
    assign w_count_m1  = r_count - 1'b1;
    assign o_res_valid = (r_state == S_FIN);
    assign o_res       = r_res;
    assign o_count     = r_count;

    // next-state and memory port control
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idx   = r_idx;
        n_widx  = r_widx;
        n_pend  = r_pend;
        n_key   = r_key;
        n_res   = r_res;
        o_we    = 1'b0;
        o_waddr = r_count[AW-1:0];
        o_wdata = i_rec;
        o_raddr = r_idx[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                // prefetch the tail in case this is a pop
                o_raddr = w_count_m1[AW-1:0];
                if (w_accept) begin
                    n_key = i_rec.id;
                    n_res = '0;
                    n_state = S_FIN;
                    unique case (i_op)
                        OP_PUSH: begin
                            if (r_count == FULL_CNT) begin
                                n_res.status = ST_FULL;
                            end else begin
                                o_we    = 1'b1;
                                n_count = r_count + 1'b1;
                                n_res.status = ST_OK;
                            end
                        end
                        OP_POP: begin
                            if (r_count == '0) begin
                                n_res.status = ST_EMPTY;
                            end else begin
                                n_state = S_POP;
                            end
                        end
                        OP_REMOVE: begin
                            if (r_count == '0) begin
                                n_res.status = ST_NOTFOUND;
                            end else begin
                                n_idx   = '0;
                                n_pend  = 1'b0;
                                n_state = S_SRCH;
                            end
                        end
                        default: begin
                            n_res.status = ST_OK;
                        end
                    endcase
                end
            end
            S_POP: begin
                n_res.status = ST_OK;
                n_res.rec    = i_rdata;
                n_count      = w_count_m1;
                n_state      = S_FIN;
            end
            S_SRCH: begin
                // one read issued and one compare done each cycle
                if (w_issue) begin
                    n_idx = r_idx + 1'b1;
                end
                n_pend = w_issue;
                if (w_match) begin
                    // the read in flight is already the first entry to move
                    n_res.status = ST_OK;
                    n_res.rec    = i_rdata;
                    n_widx       = r_idx - 1'b1;
                    n_state      = S_SHIFT;
                end else if (!w_issue) begin
                    n_res.status = ST_NOTFOUND;
                    n_state      = S_FIN;
                end
            end
            S_SHIFT: begin
                // read entry i+1, write it back at i in the next cycle
                if (w_issue) begin
                    n_idx = r_idx + 1'b1;
                end
                n_pend = w_issue;
                if (r_pend) begin
                    o_we    = 1'b1;
                    o_waddr = r_widx[AW-1:0];
                    o_wdata = i_rdata;
                    n_widx  = r_widx + 1'b1;
                end
                if (!w_issue && !r_pend) begin
                    n_count = w_count_m1;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_widx <= n_widx;
        r_key  <= n_key;
        r_res  <= n_res;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("record count above depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            ((r_count == $past(r_count) + 1'b1) || (r_count == $past(r_count) - 1'b1)))
        else $error("record count moved by more than one");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_we && (r_state == S_IDLE)) |-> (r_count < FULL_CNT))
        else $error("push written into a full list");

    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SHIFT) && r_pend) |->
            (({1'b0, r_widx} + 1'b1) < {1'b0, r_count}))
        else $error("gap close write beyond the last record");

    a_search_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |-> (r_idx <= r_count))
        else $error("search index past the record count");
`endif

endmodule

/* hdl/keyed_list_with_tail_pop.sv */
// Top level of the keyed record list: sequencer, record memory, result register.
//
//  channel   dir  tdata (low bit up)                           tuser
//  s_axis    in   item_id[30:0] item_data[62:31] zero[63]      op[1:0]
//  m_axis    out  out_id[30:0] out_data[62:31]                 status[1:0]
//                 entry_count[67:63] zero[71:68]
//
//  Push, unused ops and any op on an empty list go from idle straight to the result; pop reads the tail first.
//  Remove compares one record a cycle through the single read port, then moves
//  each later record down a slot a cycle.
//  Synchronous active-low reset empties the list; stored records are not cleared.
//  Ready is low while an op works; a result held in the output register stalls the next one.
module keyed_list_with_tail_pop #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // item_id[30:0], item_data[62:31], zero[63]
    input  logic [1:0]  i_s_axis_tuser,   // op[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,   // out_id[30:0], out_data[62:31],
                                          // entry_count[67:63], zero[71:68]
    output logic [1:0]  o_m_axis_tuser    // status[1:0]
);
    import kl_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_rec                      w_in_rec;
    logic                      w_we;
    logic [AW-1:0]             w_waddr;
    t_rec                      w_wdata;
    logic [AW-1:0]             w_raddr;
    t_rec                      w_rdata;
    logic                      w_res_valid;
    logic                      w_res_ready;
    t_res                      w_res;
    logic [CW-1:0]             w_count;
    logic [CW+CNT_OUT_W-1:0]   w_count_ext;

    logic                      r_ovld;
    t_res                      r_out_res;
    logic [CNT_OUT_W-1:0]      r_out_cnt;

    // unpack the incoming beat
    assign w_in_rec.id   = i_s_axis_tdata[ID_W-1:0];
    assign w_in_rec.data = i_s_axis_tdata[ID_W+DATA_W-1:ID_W];

    kl_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_op        (i_s_axis_tuser),
        .i_rec       (w_in_rec),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_count     (w_count)
    );

    kl_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // report the count in five bits
    assign w_count_ext = {{CNT_OUT_W{1'b0}}, w_count};

    // output register: take a new result when empty or being drained
    assign w_res_ready = !r_ovld || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_res_ready) begin
            r_ovld <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out_res <= w_res;
            r_out_cnt <= w_count_ext[CNT_OUT_W-1:0];
        end
    end

    // pack the outgoing beat
    assign o_m_axis_tvalid = r_ovld;
    assign o_m_axis_tuser  = r_out_res.status;
    assign o_m_axis_tdata  = {4'b0, r_out_cnt, r_out_res.rec.data, r_out_res.rec.id};

endmodule

/* bench/keyed_list_checker.sv */
// Checker for the keyed record list: watches both channels, predicts each reply and compares.
`timescale 1ns / 100ps

module keyed_list_checker #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // item_id[30:0], item_data[62:31], zero[63]
    input  logic [1:0]  i_s_axis_tuser,   // op[1:0]
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [71:0] i_m_axis_tdata,   // out_id[30:0], out_data[62:31],
                                          // entry_count[67:63], zero[71:68]
    input  logic [1:0]  i_m_axis_tuser,   // status[1:0]
    output int          o_fail_count,
    output int          o_pending
);
    import kl_pkg::*;

    typedef struct packed {
        logic [ST_W-1:0]      status;
        logic [ID_W-1:0]      id;
        logic [DATA_W-1:0]    data;
        logic [CNT_OUT_W-1:0] count;
    } t_reply;

    // shadow copy of the list, oldest record at index 0
    t_rec        list_mem [DEPTH];
    int unsigned list_fill;
    t_reply      reply_queue [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        list_fill    = 0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    // Apply one list operation to the shadow list and queue the reply it gives.
    task automatic apply_list_op(input logic [OP_W-1:0] op, input t_rec rec);
        t_reply reply;
        int     hit;
        reply = '0;
        reply.status = ST_OK;
        case (op)
            OP_PUSH: begin
                if (list_fill >= DEPTH) begin
                    reply.status = ST_FULL;
                end else begin
                    list_mem[list_fill] = rec;
                    list_fill++;
                end
            end
            OP_POP: begin
                if (list_fill == 0) begin
                    reply.status = ST_EMPTY;
                end else begin
                    list_fill--;
                    reply.id   = list_mem[list_fill].id;
                    reply.data = list_mem[list_fill].data;
                end
            end
            OP_REMOVE: begin
                hit = -1;
                for (int i = 0; i < list_fill; i++) begin
                    if (hit < 0 && list_mem[i].id == rec.id) begin
                        hit = i;
                    end
                end
                if (hit < 0) begin
                    reply.status = ST_NOTFOUND;
                end else begin
                    reply.id   = list_mem[hit].id;
                    reply.data = list_mem[hit].data;
                    // close the gap, keeping order
                    for (int i = hit; i + 1 < list_fill; i++) begin
                        list_mem[i] = list_mem[i + 1];
                    end
                    list_fill--;
                end
            end
            default: begin
            end
        endcase
        reply.count = CNT_OUT_W'(list_fill);
        reply_queue.push_back(reply);
    endtask

    always @(posedge i_clk) begin
        t_reply want;
        t_rec   rec;
        if (!i_rst_n) begin
            list_fill = 0;
            reply_queue.delete();
        end else begin
            // compare a result beat with the oldest prediction
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (reply_queue.size() == 0) begin
                    report_mismatch("result beat with nothing expected",
                                    i_m_axis_tdata[63:0], 64'd0);
                end else begin
                    want = reply_queue.pop_front();
                    if (i_m_axis_tuser !== want.status)
                        report_mismatch("status", 64'(i_m_axis_tuser), 64'(want.status));
                    if (i_m_axis_tdata[30:0] !== want.id)
                        report_mismatch("out_id", 64'(i_m_axis_tdata[30:0]), 64'(want.id));
                    if (i_m_axis_tdata[62:31] !== want.data)
                        report_mismatch("out_data", 64'(i_m_axis_tdata[62:31]),
                                        64'(want.data));
                    if (i_m_axis_tdata[67:63] !== want.count)
                        report_mismatch("entry_count", 64'(i_m_axis_tdata[67:63]),
                                        64'(want.count));
                    if (i_m_axis_tdata[71:68] !== 4'd0)
                        report_mismatch("tdata pad", 64'(i_m_axis_tdata[71:68]), 64'd0);
                end
            end
            // predict the reply for an accepted request beat
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                rec.id   = i_s_axis_tdata[30:0];
                rec.data = i_s_axis_tdata[62:31];
                apply_list_op(i_s_axis_tuser, rec);
            end
        end
        o_pending = reply_queue.size();
    end

endmodule

/* bench/keyed_list_with_tail_pop_test.sv */
// Testbench top for the keyed record list: clock, reset, request and reply traffic, verdict.
`timescale 1ns / 100ps

module keyed_list_with_tail_pop_test;
    import kl_pkg::*;

    localparam int DEPTH          = 16;
    localparam int RANDOM_ITEMS   = 1300;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 80;
    localparam int LIMIT_CYCLES   = 1_000_000;
    // unused op code, a no-op in the block
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;
    int          fail_count;
    int          pending;
    bit          hold_request = 1'b0;
    logic [ID_W-1:0] key_pool [8];

    always #10 i_clk = ~i_clk;

    keyed_list_with_tail_pop #(.DEPTH(DEPTH)) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    keyed_list_checker #(.DEPTH(DEPTH)) u_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_m_axis_tuser  (m_tuser),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Favor keys that were likely pushed, so removes hit often.
    function automatic logic [ID_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 75)
            return key_pool[$urandom_range(0, 7)];
        else
            return ID_W'($urandom);
    endfunction

    // Offer one request beat after a random gap and hold it until accepted.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [ID_W-1:0] key,
                             input logic [DATA_W-1:0] word);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, word, key};
        do @(posedge i_clk); while (!s_tready);
    endtask

    // Reply side: random ready with runs of no idling, and long hold-offs on request.
    initial begin
        forever begin
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge i_clk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 60)) @(posedge i_clk);
            end
        end
    end

    // Give up on a hung run.
    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("keyed_list_with_tail_pop: mismatch");
        $finish;
    end

    initial begin
        int n;
        int push_pct;
        int seg_len;
        int r;
        logic [OP_W-1:0] op;

        foreach (key_pool[i]) key_pool[i] = ID_W'($urandom);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty-list cases, extremes, removing the only record
        send_item(OP_POP, '0, '0);
        send_item(OP_REMOVE, ID_W'(5), '0);
        send_item(OP_SPARE, '1, '1);
        send_item(OP_PUSH, '1, '1);
        send_item(OP_REMOVE, '1, '0);
        send_item(OP_PUSH, '0, '0);
        // fill up with duplicate ids so remove must take the first match
        for (int i = 1; i < DEPTH; i++) begin
            send_item(OP_PUSH, ID_W'(i % 5), $urandom);
        end
        send_item(OP_PUSH, ID_W'(9), $urandom);
        send_item(OP_SPARE, '0, '0);
        send_item(OP_REMOVE, ID_W'(3), '0);
        send_item(OP_POP, '0, '0);
        send_item(OP_REMOVE, ID_W'(12345), '0);

        // random segments, each leaning toward growth, balance or shrinking
        n = 0;
        while (n < RANDOM_ITEMS) begin
            case ($urandom_range(0, 2))
                0: push_pct = 15;
                1: push_pct = 50;
                default: push_pct = 85;
            endcase
            seg_len = $urandom_range(20, 60);
            key_pool[$urandom_range(0, 7)] = ID_W'($urandom);
            for (int k = 0; k < seg_len && n < RANDOM_ITEMS; k++) begin
                r = $urandom_range(0, 99);
                if (r < push_pct)
                    op = OP_PUSH;
                else if (r < push_pct + (100 - push_pct) * 45 / 100)
                    op = OP_POP;
                else if ($urandom_range(0, 19) == 0)
                    op = OP_SPARE;
                else
                    op = OP_REMOVE;
                if (n == 300 || n == 900)
                    hold_request = 1'b1;
                send_item(op, pick_key(), $urandom);
                n++;
            end
        end
        s_tvalid <= 1'b0;

        // drain the outstanding replies, then allow for a late extra beat
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("keyed_list_with_tail_pop: match");
        else
            $display("keyed_list_with_tail_pop: mismatch");
        $finish;
    end

endmodule
